/* rtl/core/weighted_moment_accumulator_top_defines.svh */
// Assertion helpers shared by the accumulator core.
// Each helper samples on clk and is disabled while rst_n is low.
`ifndef WEIGHTED_MOMENT_ACCUMULATOR_TOP_DEFINES_SVH
`define WEIGHTED_MOMENT_ACCUMULATOR_TOP_DEFINES_SVH

// Check a property in the same cycle.
`define WMA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a consequence in the cycle after the antecedent.
`define WMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/wma_pkg.sv */
`default_nettype none

package wma_pkg;

    localparam int SUM_W     = 58;
    localparam int COUNT_W   = 16;
    localparam int WSUM_W    = 24;

    // Samples beyond this count are ignored
    localparam logic [COUNT_W-1:0] MAX_EVENTS = 16'd65535;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // Action codes
    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_ZERO_WEIGHT = 2'd1,
        ST_FULL        = 2'd2
    } status_t;

    // Snapshot of the accumulators after one item, handed to the back end
    typedef struct packed {
        logic [COUNT_W-1:0]       count;
        logic [WSUM_W-1:0]        wsum;
        logic signed [SUM_W-1:0]  s1;
        logic signed [SUM_W-1:0]  s2;
        logic signed [SUM_W-1:0]  s3;
        logic [1:0]               order;
        status_t                  status;
    } snap_t;

    // One finished result
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic signed [19:0]  mean;
        logic [29:0]         variance;
        logic [18:0]         dev;
        logic signed [20:0]  skew;
        logic signed [41:0]  raw;
        status_t             status;
    } res_t;

endpackage

`default_nettype wire

/* rtl/core/wma_front.sv */
`default_nettype none

module wma_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 in_action,
    input  wire signed [11:0]   in_value,
    input  wire [7:0]           in_weight,
    input  wire [1:0]           in_order,
    input  wire                 room,
    output logic                push,
    output wma_pkg::snap_t      push_data
);
    import wma_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_M1,
        F_M2,
        F_M3,
        F_COMMIT
    } fstate_t;

    fstate_t                 state_reg;
    logic                    add_reg;
    logic                    full_reg;
    logic signed [11:0]      x_reg;
    logic [7:0]              w_reg;
    logic [1:0]              order_reg;
    logic signed [20:0]      p1_reg;
    logic signed [32:0]      p2_reg;
    logic signed [44:0]      p3_reg;
    logic [COUNT_W-1:0]      count_reg;
    logic [WSUM_W-1:0]       wsum_reg;
    logic signed [SUM_W-1:0] s1_reg;
    logic signed [SUM_W-1:0] s2_reg;
    logic signed [SUM_W-1:0] s3_reg;

    logic                    accept;
    logic signed [20:0]      p1_full;
    logic signed [32:0]      p2_full;
    logic signed [44:0]      p3_full;
    logic [COUNT_W-1:0]      count_new;
    logic [WSUM_W-1:0]       wsum_new;
    logic signed [SUM_W-1:0] s1_new;
    logic signed [SUM_W-1:0] s2_new;
    logic signed [SUM_W-1:0] s3_new;

    assign in_ready = (state_reg == F_IDLE) && room;
    assign accept   = in_valid && in_ready;
    assign push     = (state_reg == F_COMMIT);

    // Build the weighted powers one multiply per cycle
    assign p1_full = $signed({1'b0, w_reg}) * x_reg;
    assign p2_full = p1_reg * x_reg;
    assign p3_full = p2_reg * x_reg;

    // Updated accumulators, applied at commit
    always_comb
    begin
        count_new = count_reg;
        wsum_new  = wsum_reg;
        s1_new    = s1_reg;
        s2_new    = s2_reg;
        s3_new    = s3_reg;
        if (add_reg)
        begin
            count_new = count_reg + 1'b1;
            wsum_new  = wsum_reg + WSUM_W'(w_reg);
            s1_new    = s1_reg + SUM_W'(p1_reg);
            s2_new    = s2_reg + SUM_W'(p2_reg);
            s3_new    = s3_reg + SUM_W'(p3_reg);
        end
        push_data.count = count_new;
        push_data.wsum  = wsum_new;
        push_data.s1    = s1_new;
        push_data.s2    = s2_new;
        push_data.s3    = s3_new;
        push_data.order = order_reg;
        if (full_reg)
            push_data.status = ST_FULL;
        else if (wsum_new == '0)
            push_data.status = ST_ZERO_WEIGHT;
        else
            push_data.status = ST_OK;
    end

    // Sequence one beat through the multiplies and commit it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            add_reg   <= 1'b0;
            full_reg  <= 1'b0;
            count_reg <= '0;
            wsum_reg  <= '0;
            s1_reg    <= '0;
            s2_reg    <= '0;
            s3_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        x_reg     <= in_value;
                        w_reg     <= in_weight;
                        order_reg <= in_order;
                        full_reg  <= (in_action == ACT_ADD) && (count_reg >= MAX_EVENTS);
                        add_reg   <= (in_action == ACT_ADD) && (count_reg < MAX_EVENTS);
                        state_reg <= F_M1;
                    end
                end
                F_M1:
                begin
                    p1_reg    <= p1_full;
                    state_reg <= F_M2;
                end
                F_M2:
                begin
                    p2_reg    <= p2_full;
                    state_reg <= F_M3;
                end
                F_M3:
                begin
                    p3_reg    <= p3_full;
                    state_reg <= F_COMMIT;
                end
                F_COMMIT:
                begin
                    count_reg <= count_new;
                    wsum_reg  <= wsum_new;
                    s1_reg    <= s1_new;
                    s2_reg    <= s2_new;
                    s3_reg    <= s3_new;
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/wma_queue.sv */
`default_nettype none
`include "weighted_moment_accumulator_top_defines.svh"

module wma_queue #(
    parameter int DEPTH = wma_pkg::QUEUE_DEPTH_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push,
    input  wire wma_pkg::snap_t push_data,
    output logic                room,
    input  wire                 pop,
    output logic                head_valid,
    output wma_pkg::snap_t      head_data
);
    import wma_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    snap_t              mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   fill_reg;

    assign room       = (fill_reg != CNT_W'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                fill_reg <= fill_reg + 1'b1;
            else if (pop && !push)
                fill_reg <= fill_reg - 1'b1;
        end
    end

    `WMA_ASSERT(a_no_overflow, !push || (fill_reg != CNT_W'(DEPTH)), "push into full queue")
    `WMA_ASSERT(a_no_underflow, !pop || (fill_reg != '0), "pop from empty queue")
    `WMA_ASSERT_NEXT(a_fill_up, push && !pop, fill_reg == $past(fill_reg) + 1'b1, "fill miscount")

endmodule

`default_nettype wire

/* rtl/core/wma_back.sv */
`default_nettype none
`include "weighted_moment_accumulator_top_defines.svh"

module wma_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 q_valid,
    input  wire wma_pkg::snap_t q_data,
    output logic                q_pop,
    output logic                out_valid,
    input  wire                 out_ready,
    output wma_pkg::res_t       out_res
);
    import wma_pkg::*;

    localparam int DIV_STEPS = 42;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV_LOAD,
        B_DIV_RUN,
        B_SQUARE,
        B_VAR,
        B_PROD,
        B_TVAL,
        B_SQRT,
        B_CB_SQ,
        B_CB_CUBE,
        B_DONE
    } bstate_t;

    bstate_t             state_reg;
    snap_t               ent_reg;
    logic [1:0]          sel_reg;
    logic [41:0]         low_reg;
    logic [23:0]         rem_reg;
    logic [41:0]         quo_reg;
    logic                neg_reg;
    logic [5:0]          step_reg;
    logic signed [19:0]  mean_reg;
    logic [30:0]         msq_reg;
    logic signed [41:0]  cub_reg;
    logic [38:0]         a2_reg;
    logic [29:0]         var_reg;
    logic signed [42:0]  inner_reg;
    logic signed [62:0]  prod_reg;
    logic [62:0]         tm_reg;
    logic                tneg_reg;
    logic [18:0]         dev_reg;
    logic [20:0]         root_reg;
    logic [41:0]         sq_reg;
    logic [4:0]          bit_reg;
    logic                out_valid_reg;
    res_t                res_reg;

    logic signed [SUM_W-1:0] num;
    logic [SUM_W-1:0]        mag;
    logic [65:0]             dvd;
    logic [24:0]             div_cat;
    logic                    div_ge;
    logic [24:0]             div_diff;
    logic [23:0]             div_rem;
    logic [41:0]             div_q;
    logic [42:0]             div_s;
    logic signed [39:0]      a2_full;
    logic signed [32:0]      var_diff;
    logic [29:0]             var_clamp;
    logic [42:0]             inner_full;
    logic signed [62:0]      prod_full;
    logic signed [63:0]      t_full;
    logic [63:0]             t_mag;
    logic [18:0]             sq_try;
    logic [37:0]             sq_sq;
    logic [20:0]             cb_try;
    logic [41:0]             cb_sq;
    logic [62:0]             cb_cube;
    logic [20:0]             root_sat;
    logic signed [20:0]      skew_val;
    logic signed [41:0]      raw_val;
    logic                    zero_res_chk;
    logic                    zero_res_clear;
    logic                    out_stall;

    assign q_pop     = (state_reg == B_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Pick the numerator and form the scaled magnitude
    always_comb
    begin
        case (sel_reg)
            2'd0:    num = ent_reg.s1;
            2'd1:    num = ent_reg.s2;
            default: num = ent_reg.s3;
        endcase
        mag = num[SUM_W-1] ? SUM_W'(-num) : SUM_W'(num);
        dvd = {mag, 8'b0};
    end

    // One restoring division step per cycle
    always_comb
    begin
        div_cat  = {rem_reg, low_reg[41]};
        div_ge   = (div_cat >= {1'b0, ent_reg.wsum});
        div_diff = div_cat - {1'b0, ent_reg.wsum};
        div_rem  = div_ge ? div_diff[23:0] : div_cat[23:0];
        div_q    = {quo_reg[40:0], div_ge};
        div_s    = neg_reg ? (43'd0 - {1'b0, div_q}) : {1'b0, div_q};
    end

    // Variance and third central moment pieces
    assign a2_full    = mean_reg * mean_reg;
    assign var_diff   = $signed({2'b0, msq_reg}) - $signed({2'b0, a2_reg[38:8]});
    assign var_clamp  = var_diff[32] ? '0 :
                        ((var_diff > 33'sd1073741823) ? 30'h3FFFFFFF : var_diff[29:0]);
    assign inner_full = ({12'b0, msq_reg} << 9) + ({12'b0, msq_reg} << 8)
                        - ({4'b0, a2_reg} << 1);
    assign prod_full  = inner_reg * mean_reg;
    assign t_full     = (64'(cub_reg) <<< 16) - 64'(prod_reg);
    assign t_mag      = t_full[63] ? (64'd0 - t_full) : t_full;

    // Root trial values
    assign sq_try  = dev_reg | (19'd1 << bit_reg);
    assign sq_sq   = sq_try * sq_try;
    assign cb_try  = root_reg | (21'd1 << bit_reg);
    assign cb_sq   = cb_try * cb_try;
    assign cb_cube = sq_reg * cb_try;

    // Saturate the signed cube root and select the raw moment
    always_comb
    begin
        if (tneg_reg)
        begin
            root_sat = (root_reg > 21'd1048576) ? 21'd1048576 : root_reg;
            skew_val = -$signed(root_sat);
        end
        else
        begin
            root_sat = (root_reg > 21'd1048575) ? 21'd1048575 : root_reg;
            skew_val = $signed(root_sat);
        end
        case (ent_reg.order)
            2'd1:    raw_val = 42'(mean_reg);
            2'd2:    raw_val = $signed({11'b0, msq_reg});
            2'd3:    raw_val = cub_reg;
            default: raw_val = '0;
        endcase
    end

    // Sequence divisions, roots and the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != B_DONE))
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (q_valid)
                    begin
                        ent_reg  <= q_data;
                        sel_reg  <= 2'd0;
                        mean_reg <= '0;
                        msq_reg  <= '0;
                        cub_reg  <= '0;
                        var_reg  <= '0;
                        dev_reg  <= '0;
                        root_reg <= '0;
                        tneg_reg <= 1'b0;
                        if (q_data.wsum == '0)
                            state_reg <= B_DONE;
                        else
                            state_reg <= B_DIV_LOAD;
                    end
                end
                B_DIV_LOAD:
                begin
                    neg_reg   <= num[SUM_W-1];
                    rem_reg   <= dvd[65:42];
                    low_reg   <= dvd[41:0];
                    quo_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= B_DIV_RUN;
                end
                B_DIV_RUN:
                begin
                    rem_reg  <= div_rem;
                    quo_reg  <= div_q;
                    low_reg  <= {low_reg[40:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 6'(DIV_STEPS - 1))
                    begin
                        case (sel_reg)
                            2'd0:    mean_reg <= div_s[19:0];
                            2'd1:    msq_reg  <= div_q[30:0];
                            default: cub_reg  <= div_s[41:0];
                        endcase
                        if (sel_reg == 2'd2)
                            state_reg <= B_SQUARE;
                        else
                        begin
                            sel_reg   <= sel_reg + 1'b1;
                            state_reg <= B_DIV_LOAD;
                        end
                    end
                end
                B_SQUARE:
                begin
                    a2_reg    <= a2_full[38:0];
                    state_reg <= B_VAR;
                end
                B_VAR:
                begin
                    var_reg   <= var_clamp;
                    inner_reg <= $signed(inner_full);
                    state_reg <= B_PROD;
                end
                B_PROD:
                begin
                    prod_reg  <= prod_full;
                    state_reg <= B_TVAL;
                end
                B_TVAL:
                begin
                    tneg_reg  <= t_full[63];
                    tm_reg    <= t_mag[62:0];
                    dev_reg   <= '0;
                    bit_reg   <= 5'd18;
                    state_reg <= B_SQRT;
                end
                B_SQRT:
                begin
                    if (sq_sq <= {var_reg, 8'b0})
                        dev_reg <= sq_try;
                    if (bit_reg == '0)
                    begin
                        root_reg  <= '0;
                        bit_reg   <= 5'd20;
                        state_reg <= B_CB_SQ;
                    end
                    else
                        bit_reg <= bit_reg - 1'b1;
                end
                B_CB_SQ:
                begin
                    sq_reg    <= cb_sq;
                    state_reg <= B_CB_CUBE;
                end
                B_CB_CUBE:
                begin
                    if (cb_cube <= tm_reg)
                        root_reg <= cb_try;
                    if (bit_reg == '0)
                        state_reg <= B_DONE;
                    else
                    begin
                        bit_reg   <= bit_reg - 1'b1;
                        state_reg <= B_CB_SQ;
                    end
                end
                B_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        res_reg.count    <= ent_reg.count;
                        res_reg.mean     <= mean_reg;
                        res_reg.variance <= var_reg;
                        res_reg.dev      <= dev_reg;
                        res_reg.skew     <= skew_val;
                        res_reg.raw      <= raw_val;
                        res_reg.status   <= ent_reg.status;
                        out_valid_reg    <= 1'b1;
                        state_reg        <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Assertion helpers
    assign zero_res_chk   = out_valid_reg && (res_reg.status == ST_ZERO_WEIGHT);
    assign zero_res_clear = (res_reg.mean == '0) && (res_reg.raw == '0) && (res_reg.skew == '0);
    assign out_stall      = out_valid_reg && !out_ready;

    `WMA_ASSERT(a_zero_weight_clear, !zero_res_chk || zero_res_clear, "zero weight sum nonzero")
    `WMA_ASSERT_NEXT(a_pop_leaves_idle, q_pop, state_reg != B_IDLE, "popped entry not taken")
    `WMA_ASSERT_NEXT(a_out_hold, out_stall, out_valid_reg && $stable(res_reg), "beat lost on stall")

endmodule

`default_nettype wire

/* rtl/core/weighted_moment_accumulator_top.sv */
// Channel   Direction  tdata / tuser
// s_axis    in         tdata: sample_value, sample_weight, moment_order; tuser: action
// m_axis    out        tdata: event_total .. raw_moment_out; tuser: status
//
// Front end finishes each beat (three chained multiplies, then commit) before it takes the next.
// Back end works on one beat at a time: three 42-step divisions by the weight
// sum on one shared divider, a 19-step square root, a 21-bit cube root with a
// square step and a cube step per bit; a beat with zero weight sum skips all of these.
// A queue of QUEUE_DEPTH snapshots and the output register decouple the two sides.
// rst_n clears the accumulators, the queue and the output valid at once.
`default_nettype none

module weighted_moment_accumulator_top #(
    parameter int QUEUE_DEPTH = wma_pkg::QUEUE_DEPTH_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [23:0]   s_axis_tdata,   // sample_value[11:0], sample_weight[19:12],
                                         // moment_order[21:20], zero pad
    input  wire [0:0]    s_axis_tuser,   // action[0]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [151:0] m_axis_tdata,   // event_total[15:0], mean_out[35:16],
                                         // variance_out[65:36], deviation_out[84:66],
                                         // skew_root_out[105:85], raw_moment_out[147:106],
                                         // zero pad
    output logic [1:0]   m_axis_tuser    // status[1:0]
);
    import wma_pkg::*;

    logic  room;
    logic  push;
    snap_t push_data;
    logic  head_valid;
    snap_t head_data;
    logic  pop;
    res_t  res;

    wma_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_action (s_axis_tuser[0]),
        .in_value  ($signed(s_axis_tdata[11:0])),
        .in_weight (s_axis_tdata[19:12]),
        .in_order  (s_axis_tdata[21:20]),
        .room      (room),
        .push      (push),
        .push_data (push_data)
    );

    wma_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .room       (room),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    wma_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_data    (head_data),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (res)
    );

    // Pack the result beat
    assign m_axis_tdata = {4'b0, res.raw, res.skew, res.dev, res.variance, res.mean, res.count};
    assign m_axis_tuser = res.status;

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import wma_pkg::*;

    typedef struct packed {
        logic [15:0]        count;
        logic signed [19:0] mean;
        logic [29:0]        variance;
        logic [18:0]        dev;
        logic signed [20:0] skew;
        logic signed [41:0] raw;
        status_t            status;
    } moments_t;

    typedef struct {
        logic               act;
        logic signed [11:0] value;
        logic [7:0]         weight;
        logic [1:0]         order;
        logic               typed;   // expected result typed in below
        moments_t           want;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata;
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [151:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    // Predictor state
    longint unsigned  pred_count;
    longint unsigned  pred_wsum;
    longint           pred_sums [3];

    moments_t expected_moments [$];
    int       failures;
    bit       hold_off;

    weighted_moment_accumulator_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Truncated 256*num/den
    function automatic longint scaled_quotient(longint num, longint unsigned den);
        bit               neg;
        longint unsigned  mag;
        longint unsigned  res;
        neg = num < 0;
        mag = neg ? -num : num;
        res = (mag / den) * 256 + ((mag % den) * 256) / den;
        return neg ? -longint'(res) : longint'(res);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned m);
        longint unsigned y;
        longint unsigned t;
        y = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = y | (64'd1 << b);
            if (t * t <= m)
                y = t;
        end
        return y;
    endfunction

    function automatic longint unsigned floor_cbrt(longint unsigned m);
        longint unsigned y;
        longint unsigned t;
        y = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = y | (64'd1 << b);
            if (t * t * t <= m)
                y = t;
        end
        return y;
    endfunction

    // Advance the accumulators by one beat and work out the report
    function automatic moments_t accumulate_and_report(logic act, logic signed [11:0] value,
                                                      logic [7:0] weight, logic [1:0] order);
        moments_t         r;
        longint           x;
        longint           term;
        longint           mean;
        longint           q;
        longint           c;
        longint           v;
        longint           t;
        longint unsigned  tm;
        longint unsigned  root;
        longint unsigned  sq;
        r = '{status: ST_OK, default: 0};
        x = longint'(value);
        if (act == ACT_ADD)
        begin
            if (pred_count >= 65535)
                r.status = ST_FULL;
            else
            begin
                term = longint'(weight);
                pred_count++;
                pred_wsum += weight;
                for (int k = 0; k < 3; k++)
                begin
                    term *= x;
                    pred_sums[k] += term;
                end
            end
        end
        if (pred_wsum == 0)
        begin
            if (r.status == ST_OK)
                r.status = ST_ZERO_WEIGHT;
        end
        else
        begin
            mean = scaled_quotient(pred_sums[0], pred_wsum);
            q = scaled_quotient(pred_sums[1], pred_wsum);
            c = scaled_quotient(pred_sums[2], pred_wsum);
            sq = mean * mean;
            v = q - longint'(sq / 256);
            if (v < 0)
                v = 0;
            if (v > 1073741823)
                v = 1073741823;
            r.variance = 30'(v);
            sq = floor_sqrt(v * 256);
            r.dev = 19'((sq > 524287) ? 524287 : sq);
            t = c * 65536 - (768 * q - 2 * mean * mean) * mean;
            tm = (t < 0) ? -t : t;
            root = floor_cbrt(tm);
            if (t < 0)
                r.skew = 21'(-longint'((root > 1048576) ? 1048576 : root));
            else
                r.skew = 21'((root > 1048575) ? 1048575 : root);
            r.mean = 20'(mean);
            if (order != 0)
                r.raw = 42'(scaled_quotient(pred_sums[order - 1], pred_wsum));
        end
        r.count = pred_count[15:0];
        return r;
    endfunction

    // Offer one beat, hold it until accepted, then queue its expectation
    task automatic send_sample(logic act, logic signed [11:0] value, logic [7:0] weight,
                               logic [1:0] order, bit typed, moments_t typed_want);
        moments_t m;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {2'b00, order, weight, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        m = accumulate_and_report(act, value, weight, order);
        if (typed && m != typed_want)
            $error("typed expectation disagrees with predictor: count %0d", m.count);
        expected_moments.push_back(typed ? typed_want : m);
    endtask

    task automatic pause_sender(int cycles);
        s_axis_tvalid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Receiver stall pattern, with a long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (($urandom_range(0, 255) & 8'h70) == 0)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Compare each result beat against the oldest expectation
    always @(posedge clk)
    begin
        moments_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_moments.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                failures++;
            end
            else
            begin
                want = expected_moments.pop_front();
                if (m_axis_tdata[15:0] !== want.count)
                begin
                    $error("event_total exp %0d got %0d", want.count, m_axis_tdata[15:0]);
                    failures++;
                end
                if ($signed(m_axis_tdata[35:16]) !== want.mean)
                begin
                    $error("mean_out exp %0d got %0d", want.mean,
                           $signed(m_axis_tdata[35:16]));
                    failures++;
                end
                if (m_axis_tdata[65:36] !== want.variance)
                begin
                    $error("variance_out exp %0d got %0d", want.variance,
                           m_axis_tdata[65:36]);
                    failures++;
                end
                if (m_axis_tdata[84:66] !== want.dev)
                begin
                    $error("deviation_out exp %0d got %0d", want.dev, m_axis_tdata[84:66]);
                    failures++;
                end
                if ($signed(m_axis_tdata[105:85]) !== want.skew)
                begin
                    $error("skew_root_out exp %0d got %0d", want.skew,
                           $signed(m_axis_tdata[105:85]));
                    failures++;
                end
                if ($signed(m_axis_tdata[147:106]) !== want.raw)
                begin
                    $error("raw_moment_out exp %0d got %0d", want.raw,
                           $signed(m_axis_tdata[147:106]));
                    failures++;
                end
                if (m_axis_tuser !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, m_axis_tuser);
                    failures++;
                end
            end
        end
    end

    // Hard stop
    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        row_t     rows [$];
        moments_t zero_want;
        row_t     rw;
        int       burst;
        int       idle;
        int       wait_cycles;
        logic     act;
        logic signed [11:0] value;
        logic [7:0] weight;

        failures = 0;
        hold_off = 0;
        pred_count = 0;
        pred_wsum = 0;
        pred_sums = '{0, 0, 0};
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_ADD;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: typed rows cover reset state and zero weight sum
        zero_want = '{status: ST_ZERO_WEIGHT, default: 0};
        rows.push_back('{ACT_REPORT, 12'sd0, 8'd0, 2'd1, 1'b1, zero_want});
        zero_want.count = 1;
        rows.push_back('{ACT_ADD, -12'sd2048, 8'd0, 2'd2, 1'b1, zero_want});
        zero_want.count = 2;
        rows.push_back('{ACT_ADD, 12'sd2047, 8'd0, 2'd0, 1'b1, zero_want});
        rows.push_back('{ACT_ADD, 12'sd5, 8'd1, 2'd1, 1'b0, zero_want});
        rows.push_back('{ACT_REPORT, 12'sd0, 8'd0, 2'd0, 1'b0, zero_want});
        rows.push_back('{ACT_ADD, -12'sd2048, 8'd255, 2'd3, 1'b0, zero_want});
        rows.push_back('{ACT_ADD, 12'sd2047, 8'd255, 2'd3, 1'b0, zero_want});
        rows.push_back('{ACT_ADD, -12'sd1, 8'd128, 2'd2, 1'b0, zero_want});
        rows.push_back('{ACT_ADD, 12'sd0, 8'd0, 2'd1, 1'b0, zero_want});
        rows.push_back('{ACT_ADD, -12'sd2048, 8'd255, 2'd1, 1'b0, zero_want});
        rows.push_back('{ACT_ADD, -12'sd2048, 8'd255, 2'd2, 1'b0, zero_want});
        rows.push_back('{ACT_REPORT, 12'sd1365, 8'd170, 2'd3, 1'b0, zero_want});
        rows.push_back('{ACT_REPORT, -12'sd1366, 8'd85, 2'd0, 1'b0, zero_want});
        foreach (rows[i])
            send_sample(rows[i].act, rows[i].value, rows[i].weight, rows[i].order,
                        rows[i].typed, rows[i].want);
        pause_sender(1);

        // Long receiver hold-off while the sender keeps offering beats
        hold_off = 1;
        fork
            begin
                repeat (2000)
                    @(posedge clk);
                hold_off = 0;
            end
            begin
                for (int i = 0; i < 8; i++)
                    send_sample(1'($urandom_range(0, 1)), 12'($urandom), 8'($urandom),
                                2'($urandom_range(0, 3)), 1'b0, zero_want);
                pause_sender(1);
            end
        join

        // Random part in bursts with gaps; mostly adds, some near-constant data
        for (int n = 0; n < 1730; )
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++)
            begin
                act = ($urandom_range(0, 5) == 0) ? ACT_REPORT : ACT_ADD;
                case ($urandom_range(0, 3))
                    0: value = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
                    1: value = $signed(12'($urandom_range(0, 40))) - 12'sd20;
                    default: value = 12'($urandom);
                endcase
                weight = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
                send_sample(act, value, weight, 2'($urandom_range(0, 3)), 1'b0, zero_want);
                n++;
            end
            idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
            if (idle > 0)
                pause_sender(idle);
        end
        s_axis_tvalid <= 1'b0;

        // Drain
        wait_cycles = 0;
        while (expected_moments.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (400)
            @(posedge clk);
        if (failures == 0 && expected_moments.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
